// ----- sv/bom_pkg.sv -----
// Shared constants for the box overlap metrics unit.
package bom_pkg;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
endpackage

// ----- sv/bom_if.sv -----
// Request and result channel interfaces for the box overlap metrics unit.
interface bom_in_if #(
  parameter int COORD_BITS = bom_pkg::COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_a_x;
  logic [COORD_BITS-1:0] box_a_y;
  logic [COORD_BITS-1:0] box_a_width;
  logic [COORD_BITS-1:0] box_a_height;
  logic [COORD_BITS-1:0] box_b_x;
  logic [COORD_BITS-1:0] box_b_y;
  logic [COORD_BITS-1:0] box_b_width;
  logic [COORD_BITS-1:0] box_b_height;
  modport source (output valid, box_a_x, box_a_y, box_a_width, box_a_height,
                  box_b_x, box_b_y, box_b_width, box_b_height, input ready);
  modport sink   (input valid, box_a_x, box_a_y, box_a_width, box_a_height,
                  box_b_x, box_b_y, box_b_width, box_b_height, output ready);
endinterface

interface bom_out_if #(
  parameter int FRAC_BITS = bom_pkg::FRAC_BITS
);
  logic                       valid;
  logic                       ready;
  logic [FRAC_BITS:0]         iou_score;
  logic signed [FRAC_BITS+1:0] giou_score;
  logic [FRAC_BITS+1:0]       dist_loss;
  logic                       degenerate;
  modport source (output valid, iou_score, giou_score, dist_loss, degenerate, input ready);
  modport sink   (input valid, iou_score, giou_score, dist_loss, degenerate, output ready);
endinterface

// ----- sv/box_overlap_metrics_unit.sv -----
// Box overlap metrics unit: IoU, GIoU and DIoU loss for a pair of boxes.
//
// A request on in_ch carries two boxes (left, top, width, height). The result
// on out_ch carries iou_score, giou_score, dist_loss (fixed point with
// FRAC_BITS fraction bits) and degenerate, which is set with all scores zero
// when the union or the enclosing area is zero.
// Both channels use valid/ready; a transfer happens when both are high.
// The path runs through four stages of geometry, products, sums and operands,
// FRAC_BITS + 1 division cells and one output register.
// Throughput is one request per cycle while out_ch does not stall; the chain
// of division cells decides one quotient bit per cell for all three quotients.
// Each stage stalls only when it is full and the next one cannot take its
// data, so bubbles close up and requests keep entering while a result waits.
// A stalled result holds on out_ch until taken. Synchronous reset (rst_n low)
// empties every stage; no request or result is lost or repeated.
module box_overlap_metrics_unit #(
  parameter int COORD_BITS = bom_pkg::COORD_BITS,
  parameter int FRAC_BITS  = bom_pkg::FRAC_BITS
) (
  input logic       clk,
  input logic       rst_n,
  bom_in_if.sink    in_ch,
  bom_out_if.source out_ch
);
  localparam int DW = 2*COORD_BITS + 3;
  localparam int QW = FRAC_BITS + 1;
  localparam int NC = FRAC_BITS + 1;

  logic [NC:0]                v;
  logic [NC:0]                rdy;
  logic [NC:0][2:0][DW:0]     rem;
  logic [NC:0][2:0][DW-1:0]   den;
  logic [NC:0][2:0][QW-1:0]   quo;
  logic [NC:0]                dg;

  bom_front #(.COORD_BITS(COORD_BITS), .DW(DW)) u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ax (in_ch.box_a_x), .ay (in_ch.box_a_y),
    .aw (in_ch.box_a_width), .ah (in_ch.box_a_height),
    .bx (in_ch.box_b_x), .by (in_ch.box_b_y),
    .bw (in_ch.box_b_width), .bh (in_ch.box_b_height),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .num (rem[0]),
    .den (den[0]),
    .degen (dg[0])
  );
  assign quo[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    bom_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk, .rst_n,
      .in_valid (v[i]), .in_ready (rdy[i]),
      .rem_in (rem[i]), .den_in (den[i]), .quo_in (quo[i]), .degen_in (dg[i]),
      .out_valid (v[i+1]), .out_ready (rdy[i+1]),
      .rem_out (rem[i+1]), .den_out (den[i+1]), .quo_out (quo[i+1]),
      .degen_out (dg[i+1])
    );
  end

  // output register
  logic                      ov_r;
  logic [FRAC_BITS:0]        iou_r, iou_nxt;
  logic signed [FRAC_BITS+1:0] giou_r, giou_nxt;
  logic [FRAC_BITS+1:0]      diou_r, diou_nxt;
  logic                      degen_r;

  assign rdy[NC] = !ov_r || out_ch.ready;

  always_comb begin
    iou_nxt  = dg[NC] ? '0 : quo[NC][0];
    giou_nxt = dg[NC] ? '0 : $signed({1'b0, quo[NC][0]} - {1'b0, quo[NC][1]});
    diou_nxt = dg[NC] ? '0 :
               ((FRAC_BITS+2)'(1) << FRAC_BITS) - {1'b0, quo[NC][0]} + {1'b0, quo[NC][2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (rdy[NC]) ov_r <= v[NC];
  end

  always_ff @(posedge clk) begin
    if (rdy[NC]) begin
      iou_r   <= iou_nxt;
      giou_r  <= giou_nxt;
      diou_r  <= diou_nxt;
      degen_r <= dg[NC];
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.iou_score  = iou_r;
  assign out_ch.giou_score = giou_r;
  assign out_ch.dist_loss  = diou_r;
  assign out_ch.degenerate = degen_r;
endmodule

// ----- sv/bom_front.sv -----
// Geometry, area products and divider operands: four pipeline stages.
module bom_front #(
  parameter int COORD_BITS = bom_pkg::COORD_BITS,
  parameter int DW         = 2*COORD_BITS+3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0][DW:0]      num,
  output logic [2:0][DW-1:0]    den,
  output logic                  degen
);
  localparam int E = COORD_BITS + 1;
  localparam int P = 2*E;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: edges, overlaps, enclosing extents, centre offsets
  logic [E-1:0] ar, ab, br, bb, lox, hix, loy, hiy, cxa, cxb, cya, cyb;
  logic [E-1:0] iw_nxt, ih_nxt, cw_nxt, ch_nxt, dx_nxt, dy_nxt;
  logic [E-1:0] iw_r, ih_r, cw_r, ch_r, dx_r, dy_r;
  logic [COORD_BITS-1:0] aw_r, ah_r, bw_r, bh_r;

  always_comb begin
    ar  = E'(ax) + E'(aw);
    ab  = E'(ay) + E'(ah);
    br  = E'(bx) + E'(bw);
    bb  = E'(by) + E'(bh);
    lox = (ax > bx) ? E'(ax) : E'(bx);
    hix = (ar < br) ? ar : br;
    loy = (ay > by) ? E'(ay) : E'(by);
    hiy = (ab < bb) ? ab : bb;
    iw_nxt = (hix > lox) ? hix - lox : '0;
    ih_nxt = (hiy > loy) ? hiy - loy : '0;
    cw_nxt = ((ar > br) ? ar : br) - ((ax < bx) ? E'(ax) : E'(bx));
    ch_nxt = ((ab > bb) ? ab : bb) - ((ay < by) ? E'(ay) : E'(by));
    cxa = E'(ax) + E'(aw >> 1);
    cxb = E'(bx) + E'(bw >> 1);
    cya = E'(ay) + E'(ah >> 1);
    cyb = E'(by) + E'(bh >> 1);
    dx_nxt = (cxa > cxb) ? cxa - cxb : cxb - cxa;
    dy_nxt = (cya > cyb) ? cya - cyb : cyb - cya;
  end

  // stage 2: products
  logic [P-1:0] inter2_r, aa2_r, ba2_r, car2_r, dx2_r, dy2_r, cw2_r, ch2_r;
  // stage 3: sums
  logic [P-1:0] inter3_r, uni3_r, car3_r;
  logic [P:0]   d2_r, c2_r;
  // stage 4: operands
  logic [P-1:0] inter4_r, uni4_r, car4_r, emp4_r;
  logic [P:0]   d24_r, c24_r;
  logic         degen4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      iw_r <= iw_nxt; ih_r <= ih_nxt; cw_r <= cw_nxt; ch_r <= ch_nxt;
      dx_r <= dx_nxt; dy_r <= dy_nxt;
      aw_r <= aw; ah_r <= ah; bw_r <= bw; bh_r <= bh;
    end
    if (rdy2) begin
      inter2_r <= P'(iw_r) * P'(ih_r);
      aa2_r    <= P'(aw_r) * P'(ah_r);
      ba2_r    <= P'(bw_r) * P'(bh_r);
      car2_r   <= P'(cw_r) * P'(ch_r);
      dx2_r    <= P'(dx_r) * P'(dx_r);
      dy2_r    <= P'(dy_r) * P'(dy_r);
      cw2_r    <= P'(cw_r) * P'(cw_r);
      ch2_r    <= P'(ch_r) * P'(ch_r);
    end
    if (rdy3) begin
      inter3_r <= inter2_r;
      uni3_r   <= aa2_r + ba2_r - inter2_r;
      car3_r   <= car2_r;
      d2_r     <= (P+1)'(dx2_r) + (P+1)'(dy2_r);
      c2_r     <= (P+1)'(cw2_r) + (P+1)'(ch2_r);
    end
    if (rdy4) begin
      inter4_r <= inter3_r;
      uni4_r   <= uni3_r;
      car4_r   <= car3_r;
      emp4_r   <= car3_r - uni3_r;
      d24_r    <= d2_r;
      c24_r    <= c2_r;
      degen4_r <= (uni3_r == '0) || (car3_r == '0);
    end
  end

  assign out_valid = v4_r;
  assign degen     = degen4_r;
  assign num[0]    = (DW+1)'(inter4_r);
  assign num[1]    = (DW+1)'(emp4_r);
  assign num[2]    = (DW+1)'(d24_r);
  assign den[0]    = DW'(uni4_r);
  assign den[1]    = DW'(car4_r);
  assign den[2]    = DW'(c24_r);
endmodule

// ----- sv/bom_div_cell.sv -----
// One restoring-division cell: decides one quotient bit of three divisions.
module bom_div_cell #(
  parameter int DW = 2*bom_pkg::COORD_BITS+3,
  parameter int QW = bom_pkg::FRAC_BITS+1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0][DW:0]   rem_in,
  input  logic [2:0][DW-1:0] den_in,
  input  logic [2:0][QW-1:0] quo_in,
  input  logic               degen_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0][DW:0]   rem_out,
  output logic [2:0][DW-1:0] den_out,
  output logic [2:0][QW-1:0] quo_out,
  output logic               degen_out
);
  logic               v_r;
  logic [2:0][DW:0]   rem_r, rem_nxt;
  logic [2:0][DW-1:0] den_r;
  logic [2:0][QW-1:0] quo_r, quo_nxt;
  logic               degen_r;
  logic [DW:0]        diff;
  logic               take;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      take       = rem_in[k] >= {1'b0, den_in[k]};
      diff       = take ? rem_in[k] - {1'b0, den_in[k]} : rem_in[k];
      rem_nxt[k] = {diff[DW-1:0], 1'b0};
      quo_nxt[k] = {quo_in[k][QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r   <= rem_nxt;
      den_r   <= den_in;
      quo_r   <= quo_nxt;
      degen_r <= degen_in;
    end
  end

  assign out_valid = v_r;
  assign rem_out   = rem_r;
  assign den_out   = den_r;
  assign quo_out   = quo_r;
  assign degen_out = degen_r;
endmodule

// ----- sv/bom_checker.sv -----
// Port-level checks for the box overlap metrics unit, bound to the top level.
module bom_checker #(
  parameter int FRAC_BITS = bom_pkg::FRAC_BITS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [FRAC_BITS:0]          iou_score,
  input logic signed [FRAC_BITS+1:0] giou_score,
  input logic [FRAC_BITS+1:0]        dist_loss,
  input logic                        degenerate
);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> iou_score == '0 && giou_score == '0 && dist_loss == '0)
    else $error("degenerate result with nonzero scores");

  a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> iou_score <= ONE)
    else $error("iou above one");

  a_giou_le_iou: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !degenerate |-> giou_score <= $signed({1'b0, iou_score}))
    else $error("giou above iou");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(iou_score) && $stable(dist_loss))
    else $error("stalled result changed");
endmodule

bind box_overlap_metrics_unit bom_checker #(.FRAC_BITS(FRAC_BITS)) u_bom_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .iou_score  (out_ch.iou_score),
  .giou_score (out_ch.giou_score),
  .dist_loss  (out_ch.dist_loss),
  .degenerate (out_ch.degenerate)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the box overlap metrics unit: directed and random box pairs with checking.
module testbench;
  localparam int COORD_W = bom_pkg::COORD_BITS;
  localparam int FRAC_W  = bom_pkg::FRAC_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  } box_pair_t;

  typedef struct packed {
    logic [FRAC_W:0]          iou;
    logic signed [FRAC_W+1:0] giou;
    logic [FRAC_W+1:0]        diou;
    logic                     degen;
  } scores_t;

  localparam int LATENCY = FRAC_W + 6;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  bom_in_if  #(.COORD_BITS(COORD_W)) in_ch ();
  bom_out_if #(.FRAC_BITS(FRAC_W))   out_ch ();

  box_overlap_metrics_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  box_pair_t pending_pairs[$];
  scores_t   expected_scores[$];
  int        error_count;
  int        sent_count;
  int        result_count;
  int        degen_count;
  int        cycle_count;
  int        in_idle_pct;
  int        out_idle_pct;
  int        hold_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned ovl(longint unsigned a0, longint unsigned a1,
                                          longint unsigned b0, longint unsigned b1);
    longint unsigned lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic scores_t score_pair(box_pair_t p);
    longint unsigned ax, ay, aw, ah, bx, by, bw, bh, ar, ab, br, bb;
    longint unsigned inter, uni, cw, ch, carea, iou, empty, dx, dy, d2, c2, pen;
    longint unsigned ca, cb;
    scores_t s;
    ax = 64'(p.ax); ay = 64'(p.ay); aw = 64'(p.aw); ah = 64'(p.ah);
    bx = 64'(p.bx); by = 64'(p.by); bw = 64'(p.bw); bh = 64'(p.bh);
    ar = ax + aw; ab = ay + ah; br = bx + bw; bb = by + bh;
    inter = ovl(ax, ar, bx, br) * ovl(ay, ab, by, bb);
    uni = aw * ah + bw * bh - inter;
    cw = ((ar > br) ? ar : br) - ((ax < bx) ? ax : bx);
    ch = ((ab > bb) ? ab : bb) - ((ay < by) ? ay : by);
    carea = cw * ch;
    s = '0;
    if (uni == 0 || carea == 0) begin
      s.degen = 1'b1;
      return s;
    end
    iou = (inter << FRAC_W) / uni;
    empty = ((carea - uni) << FRAC_W) / carea;
    ca = ax + (aw >> 1);
    cb = bx + (bw >> 1);
    dx = (ca > cb) ? ca - cb : cb - ca;
    ca = ay + (ah >> 1);
    cb = by + (bh >> 1);
    dy = (ca > cb) ? ca - cb : cb - ca;
    d2 = dx * dx + dy * dy;
    c2 = cw * cw + ch * ch;
    pen = (c2 != 0) ? (d2 << FRAC_W) / c2 : 64'd0;
    s.iou  = iou[FRAC_W:0];
    s.giou = (FRAC_W+2)'(iou - empty);
    s.diou = (FRAC_W+2)'(((64'd1 << FRAC_W) - iou) + pen);
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got, want);
  endtask

  task automatic queue_pair(box_pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  // Driver: present the head of the queue, advance on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_scores = {expected_scores, score_pair(pending_pairs.pop_front())};
        sent_count++;
      end
      if (pending_pairs.size() > 0 && !(in_ch.valid && !in_ch.ready)
          && $urandom_range(99) < in_idle_pct) begin
        in_ch.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.box_a_x, in_ch.box_a_y, in_ch.box_a_width, in_ch.box_a_height,
         in_ch.box_b_x, in_ch.box_b_y, in_ch.box_b_width, in_ch.box_b_height}
          <= pending_pairs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result, then decide ready for the next cycle.
  always @(posedge clk) begin
    scores_t want;
    cycle_count++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_scores.size() == 0) begin
          report_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = expected_scores.pop_front();
          if (out_ch.iou_score !== want.iou)
            report_mismatch("iou_score", out_ch.iou_score, want.iou);
          if (out_ch.giou_score !== want.giou)
            report_mismatch("giou_score", out_ch.giou_score, want.giou);
          if (out_ch.dist_loss !== want.diou)
            report_mismatch("dist_loss", out_ch.dist_loss, want.diou);
          if (out_ch.degenerate !== want.degen)
            report_mismatch("degenerate", out_ch.degenerate, want.degen);
          if (want.degen) degen_count++;
        end
        result_count++;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'($urandom_range(15));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // Mostly place box b near box a so that overlaps are common.
    if ($urandom_range(3) != 0) begin
      p.ax = COORD_W'($urandom_range(3000));
      p.ay = COORD_W'($urandom_range(3000));
      p.aw = COORD_W'($urandom_range(800));
      p.ah = COORD_W'($urandom_range(800));
      p.bx = p.ax + COORD_W'($urandom_range(900)) - COORD_W'($urandom_range(300));
      p.by = p.ay + COORD_W'($urandom_range(900)) - COORD_W'($urandom_range(300));
      p.bw = COORD_W'($urandom_range(800));
      p.bh = COORD_W'($urandom_range(800));
    end
    return p;
  endfunction

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_scores.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.box_a_x, in_ch.box_a_y, in_ch.box_a_width, in_ch.box_a_height,
     in_ch.box_b_x, in_ch.box_b_y, in_ch.box_b_width, in_ch.box_b_height} = '0;
    out_ch.ready = 1'b0;
    error_count = 0; sent_count = 0; result_count = 0; degen_count = 0;
    cycle_count = 0; hold_cycles = 0;
    in_idle_pct = 11;
    out_idle_pct = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all zero, full extremes, identical, disjoint, touching, nested, zero-size.
    queue_pair('0);
    queue_pair('1);
    queue_pair({12'd0, 12'd0, 12'd4095, 12'd4095,
                12'd0, 12'd0, 12'd4095, 12'd4095});
    queue_pair({12'd0, 12'd0, 12'd4095, 12'd4095,
                12'd4095, 12'd4095, 12'd4095, 12'd4095});
    queue_pair({12'd10, 12'd10, 12'd20, 12'd20,
                12'd10, 12'd10, 12'd20, 12'd20});
    queue_pair({12'd0, 12'd0, 12'd10, 12'd10,
                12'd100, 12'd200, 12'd10, 12'd10});
    queue_pair({12'd0, 12'd0, 12'd10, 12'd10,
                12'd10, 12'd0, 12'd10, 12'd10});
    queue_pair({12'd0, 12'd0, 12'd10, 12'd10,
                12'd0, 12'd10, 12'd10, 12'd10});
    queue_pair({12'd0, 12'd0, 12'd100, 12'd100,
                12'd20, 12'd30, 12'd7, 12'd9});
    queue_pair({12'd5, 12'd5, 12'd0, 12'd0,
                12'd5, 12'd5, 12'd0, 12'd0});
    queue_pair({12'd5, 12'd5, 12'd0, 12'd8,
                12'd5, 12'd9, 12'd0, 12'd3});
    queue_pair({12'd5, 12'd5, 12'd0, 12'd0,
                12'd50, 12'd60, 12'd0, 12'd0});
    queue_pair({12'd0, 12'd0, 12'd1, 12'd1,
                12'd4095, 12'd4095, 12'd1, 12'd1});
    queue_pair({12'd100, 12'd100, 12'd3, 12'd5,
                12'd101, 12'd99, 12'd7, 12'd2});
    queue_pair({12'd4095, 12'd0, 12'd4095, 12'd1,
                12'd0, 12'd4095, 12'd1, 12'd4095});
    queue_pair({12'hAAA, 12'h555, 12'hAAA, 12'h555,
                12'h555, 12'hAAA, 12'h555, 12'hAAA});
    drain();

    // Random, phase one: sender idles rarely, receiver often.
    repeat (280) queue_pair(rand_pair());
    drain();
    // Random, phase two: roles swapped, with one long receiver hold-off.
    in_idle_pct = 59;
    out_idle_pct = 11;
    hold_cycles = 200;
    repeat (280) queue_pair(rand_pair());
    drain();
    // Random, phase three: no idling at all.
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (280) queue_pair(rand_pair());
    drain();

    repeat (LATENCY * 4) @(posedge clk);
    $display("sent %0d box pairs, checked %0d results (%0d degenerate)",
             sent_count, result_count, degen_count);
    $display("covered three idle mixes and a long output stall");
    if (error_count == 0 && expected_scores.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/bom_pkg.sv
sv/bom_if.sv
sv/bom_front.sv
sv/bom_div_cell.sv
sv/box_overlap_metrics_unit.sv
sv/bom_checker.sv
verif/testbench.sv
